FILE: hdl/sacl_pkg.sv
// Shared types, constants and helpers for the subnet access-list match table.
`default_nettype none

package sacl_pkg;

  localparam int unsigned ADDR_BITS             = 32;
  localparam int unsigned PLEN_BITS             = 6;
  localparam int unsigned ZONE_IN_BITS          = 8;
  localparam int unsigned DEFAULT_TABLE_ENTRIES = 16;
  localparam int unsigned DEFAULT_ZONE_ID_BITS  = 8;

  localparam logic [PLEN_BITS-1:0] MAX_PREFIX = PLEN_BITS'(32);

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_FIRST   = 2'd1,
    CMD_LONGEST = 2'd2
  } cmd_e;

  // One command as it travels down the row of cells, with its partial result.
  typedef struct packed {
    logic                    valid;
    logic [1:0]              cmd;
    logic [ADDR_BITS-1:0]    address;
    logic [PLEN_BITS-1:0]    plen;
    logic [ZONE_IN_BITS-1:0] zone;
    logic                    hit;
    logic [PLEN_BITS-1:0]    best;
    logic [ZONE_IN_BITS-1:0] mz;
    logic                    rej;
  } tok_t;

  function automatic logic [PLEN_BITS-1:0] sat_prefix(input logic [PLEN_BITS-1:0] plen);
    return (plen > MAX_PREFIX) ? MAX_PREFIX : plen;
  endfunction

  // Upper plen bits set; a shift by the full width yields zero, so 32 gives all ones.
  function automatic logic [ADDR_BITS-1:0] prefix_mask(input logic [PLEN_BITS-1:0] plen);
    return ~({ADDR_BITS{1'b1}} >> plen);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sacl_req_if.sv
// Request channel: command, address, prefix length and zone id with valid/ready.
`default_nettype none

interface sacl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] address;
  logic [5:0]  prefix_len;
  logic [7:0]  zone_id;

  modport source (output valid, output cmd, output address, output prefix_len,
                  output zone_id, input ready);
  modport sink   (input valid, input cmd, input address, input prefix_len,
                  input zone_id, output ready);
endinterface

`default_nettype wire

FILE: hdl/sacl_rsp_if.sv
// Response channel: hit, matched zone and insert-rejected flag with valid/ready.
`default_nettype none

interface sacl_rsp_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [7:0] match_zone;
  logic       insert_rejected;

  modport source (output valid, output hit, output match_zone, output insert_rejected,
                  input ready);
  modport sink   (input valid, input hit, input match_zone, input insert_rejected,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/sacl_cell.sv
// One table cell: holds a single entry and updates the passing command beat.
`default_nettype none

module sacl_cell #(
  parameter int unsigned CELL_INDEX    = 0,
  parameter int unsigned TABLE_ENTRIES = sacl_pkg::DEFAULT_TABLE_ENTRIES,
  parameter int unsigned ZONE_ID_BITS  = sacl_pkg::DEFAULT_ZONE_ID_BITS,
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  advance,
  input  sacl_pkg::tok_t       tok_in,
  input  wire [IDX_W-1:0]      idx_in,
  output sacl_pkg::tok_t       tok_out,
  output logic [IDX_W-1:0]     idx_out
);

  logic                              ent_valid;
  logic [sacl_pkg::ADDR_BITS-1:0]    ent_address;
  logic [sacl_pkg::PLEN_BITS-1:0]    ent_prefix;
  logic [ZONE_ID_BITS-1:0]           ent_zone;

  sacl_pkg::tok_t                    tok_next;
  logic                              match;
  logic                              write_en;
  logic [sacl_pkg::ADDR_BITS-1:0]    mask;

  always_comb begin
    mask     = sacl_pkg::prefix_mask(ent_prefix);
    match    = ent_valid && (((tok_in.address ^ ent_address) & mask) == '0);
    write_en = 1'b0;
    tok_next = tok_in;
    case (tok_in.cmd)
      sacl_pkg::CMD_INSERT: begin
        write_en = tok_in.valid && !tok_in.rej && (idx_in == IDX_W'(CELL_INDEX));
      end
      sacl_pkg::CMD_FIRST: begin
        if (match && !tok_in.hit) begin
          tok_next.hit = 1'b1;
          tok_next.mz  = sacl_pkg::ZONE_IN_BITS'(ent_zone);
        end
      end
      sacl_pkg::CMD_LONGEST: begin
        // Greater-or-equal lets a later entry win a tie on prefix length.
        if (match && (!tok_in.hit || ent_prefix >= tok_in.best)) begin
          tok_next.hit  = 1'b1;
          tok_next.best = ent_prefix;
          tok_next.mz   = sacl_pkg::ZONE_IN_BITS'(ent_zone);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
      tok_out   <= '0;
      idx_out   <= '0;
    end else if (advance) begin
      tok_out <= tok_next;
      idx_out <= idx_in;
      if (write_en) begin
        ent_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && write_en) begin
      ent_address <= tok_in.address;
      ent_prefix  <= tok_in.plen;
      ent_zone    <= ZONE_ID_BITS'(tok_in.zone);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/subnet_acl_match_table.sv
// Top level of the subnet access-list match table: a row of entry cells.
//
//   port   dir   payload                                   beat taken when
//   req    in    cmd, address, prefix_len, zone_id         req.valid && req.ready
//   rsp    out   hit, match_zone, insert_rejected          rsp.valid && rsp.ready
//
// Every command enters the row of TABLE_ENTRIES cells and moves one cell per cycle unless
// the row stalls, so one command is taken per cycle and its response leaves the last cell.
// Inserts and lookups share the row, so a lookup always sees every earlier insert.
// Reset clears the entry count and all cell valid bits; no clearing pass is needed.
// A response held on rsp stalls the whole row, and req.ready drops in the same cycle.
`default_nettype none

module subnet_acl_match_table #(
  parameter int unsigned TABLE_ENTRIES = sacl_pkg::DEFAULT_TABLE_ENTRIES,
  parameter int unsigned ZONE_ID_BITS  = sacl_pkg::DEFAULT_ZONE_ID_BITS
) (
  input wire           clk,
  input wire           rst,
  sacl_req_if.sink     req,
  sacl_rsp_if.source   rsp
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  entry_count_next;
  logic              full;
  logic              advance;
  logic              accept;

  sacl_pkg::tok_t    tok_chain [0:TABLE_ENTRIES];
  logic [IDX_W-1:0]  idx_chain [0:TABLE_ENTRIES];

  assign advance   = !tok_chain[TABLE_ENTRIES].valid || rsp.ready;
  assign req.ready = advance;
  assign accept    = req.valid && advance;
  assign full      = (entry_count == CNT_W'(TABLE_ENTRIES));

  always_comb begin
    tok_chain[0].valid   = req.valid;
    tok_chain[0].cmd     = req.cmd;
    tok_chain[0].address = req.address;
    tok_chain[0].plen    = sacl_pkg::sat_prefix(req.prefix_len);
    tok_chain[0].zone    = req.zone_id;
    tok_chain[0].hit     = 1'b0;
    tok_chain[0].best    = '0;
    tok_chain[0].mz      = '0;
    tok_chain[0].rej     = (req.cmd == sacl_pkg::CMD_INSERT) && full;
    idx_chain[0]         = full ? '0 : entry_count[IDX_W-1:0];

    entry_count_next = entry_count;
    if (accept && (req.cmd == sacl_pkg::CMD_INSERT) && !full) begin
      entry_count_next = entry_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else begin
      entry_count <= entry_count_next;
    end
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    sacl_cell #(
      .CELL_INDEX    (i),
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ZONE_ID_BITS  (ZONE_ID_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .tok_in  (tok_chain[i]),
      .idx_in  (idx_chain[i]),
      .tok_out (tok_chain[i+1]),
      .idx_out (idx_chain[i+1])
    );
  end

  assign rsp.valid           = tok_chain[TABLE_ENTRIES].valid;
  assign rsp.hit             = tok_chain[TABLE_ENTRIES].hit;
  assign rsp.match_zone      = tok_chain[TABLE_ENTRIES].mz;
  assign rsp.insert_rejected = tok_chain[TABLE_ENTRIES].rej;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count exceeds table size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (accept && req.cmd == sacl_pkg::CMD_INSERT && !full)
      |=> entry_count == $past(entry_count) + CNT_W'(1))
    else $error("accepted insert did not advance the entry count");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && req.cmd == sacl_pkg::CMD_INSERT && full) |=> $stable(entry_count))
    else $error("rejected insert changed the entry count");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.hit) |-> rsp.match_zone == '0)
    else $error("miss response carries a nonzero zone");

  a_rej_no_hit: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.insert_rejected) |-> !rsp.hit)
    else $error("rejected insert reported a hit");
`endif

endmodule

`default_nettype wire

FILE: bench/acl_scoreboard.sv
// Checker for the access-list table: predicts each response from request beats and compares.
module acl_scoreboard #(
  parameter int unsigned TABLE_ENTRIES = sacl_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic clk,
  input  logic rst,
  sacl_req_if  req,
  sacl_rsp_if  rsp,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sacl_pkg::*;

  localparam int unsigned SHOWN_LIMIT = 50;

  typedef struct packed {
    logic       hit;
    logic [7:0] zone;
    logic       rejected;
  } acl_result_t;

  logic [31:0] subnet_addr [TABLE_ENTRIES];
  logic [5:0]  subnet_plen [TABLE_ENTRIES];
  logic [7:0]  subnet_zone [TABLE_ENTRIES];
  int unsigned subnet_count;
  acl_result_t expected_results[$];
  int          fail_count = 0;
  int          outstanding = 0;

  assign errors  = fail_count;
  assign pending = outstanding;

  function automatic logic [31:0] subnet_mask(logic [5:0] plen);
    if (plen == 0) return '0;
    return 32'hFFFF_FFFF << (32 - int'(plen));
  endfunction

  function automatic logic covers(int unsigned idx, logic [31:0] client);
    return ((client ^ subnet_addr[idx]) & subnet_mask(subnet_plen[idx])) == '0;
  endfunction

  // Applies one command to the predicted table and returns the response it should give.
  function automatic acl_result_t apply_command(logic [1:0] cmd, logic [31:0] address,
                                                logic [5:0] plen, logic [7:0] zone);
    acl_result_t res;
    logic [5:0]  best;
    res  = '0;
    best = '0;
    case (cmd)
      CMD_INSERT: begin
        if (subnet_count >= TABLE_ENTRIES) begin
          res.rejected = 1'b1;
        end else begin
          subnet_addr[subnet_count] = address;
          subnet_plen[subnet_count] = (plen > MAX_PREFIX) ? MAX_PREFIX : plen;
          subnet_zone[subnet_count] = zone;
          subnet_count++;
        end
      end
      CMD_FIRST: begin
        for (int unsigned i = 0; i < subnet_count; i++) begin
          if (!res.hit && covers(i, address)) begin
            res.hit  = 1'b1;
            res.zone = subnet_zone[i];
          end
        end
      end
      CMD_LONGEST: begin
        // Equal prefixes go to the later entry, hence the >= comparison.
        for (int unsigned i = 0; i < subnet_count; i++) begin
          if (covers(i, address) && (!res.hit || subnet_plen[i] >= best)) begin
            res.hit  = 1'b1;
            best     = subnet_plen[i];
            res.zone = subnet_zone[i];
          end
        end
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= SHOWN_LIMIT)
      $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin : check_beats
    acl_result_t got;
    acl_result_t want;
    acl_result_t fresh;
    if (rst) begin
      expected_results.delete();
      subnet_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = {rsp.hit, rsp.match_zone, rsp.insert_rejected};
        if (expected_results.size() == 0) begin
          report("response beat with nothing outstanding", 32'(got), '0);
        end else begin
          want = expected_results.pop_front();
          if (got.hit !== want.hit) report("hit", 32'(got.hit), 32'(want.hit));
          if (got.zone !== want.zone) report("match_zone", 32'(got.zone), 32'(want.zone));
          if (got.rejected !== want.rejected)
            report("insert_rejected", 32'(got.rejected), 32'(want.rejected));
        end
      end
      if (req.valid && req.ready) begin
        fresh = apply_command(req.cmd, req.address, req.prefix_len, req.zone_id);
        expected_results.insert(expected_results.size(), fresh);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

FILE: bench/testbench.sv
// Top of the access-list table bench: clock, reset, request and response traffic, verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sacl_pkg::*;

  localparam int unsigned SUBNETS      = DEFAULT_TABLE_ENTRIES;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam int          RANDOM_ITEMS = 1700;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES = 40;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   idle_cycles = 0;
  logic smooth_req = 1'b0;
  logic smooth_rsp = 1'b0;

  // Subnets accepted so far, kept to aim lookups at stored entries and to reuse their prefix lengths.
  logic [31:0] known_addr [SUBNETS];
  logic [5:0]  known_plen [SUBNETS];
  int unsigned known_count;

  sacl_req_if req_ch ();
  sacl_rsp_if rsp_ch ();

  subnet_acl_match_table u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  acl_scoreboard #(.TABLE_ENTRIES(SUBNETS)) u_check (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap(logic smooth);
    int r;
    r = $urandom_range(99);
    if (smooth || r < 65) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Mostly an address inside a stored subnet, sometimes one bit off inside the prefix, sometimes random.
  function automatic logic [31:0] near_address();
    int unsigned k;
    logic [31:0] host;
    logic [31:0] client;
    if (known_count == 0 || $urandom_range(99) < 15) return $urandom;
    k      = $urandom_range(known_count - 1);
    host   = (known_plen[k] >= MAX_PREFIX) ? '0 : (32'hFFFF_FFFF >> known_plen[k]);
    client = known_addr[k] ^ (host & $urandom);
    if (known_plen[k] > 0 && $urandom_range(99) < 18)
      client ^= 32'h1 << (31 - $urandom_range(known_plen[k] - 1));
    return client;
  endfunction

  // The last free slot always gets a match-all entry, so misses stay common until then.
  function automatic logic [5:0] pick_prefix();
    int r;
    r = $urandom_range(99);
    if (known_count == SUBNETS - 1) return '0;
    if (r < 12) return 6'($urandom_range(63, 33));
    if (r < 30 && known_count > 0) return known_plen[$urandom_range(known_count - 1)];
    return 6'($urandom_range(32, 1));
  endfunction

  task automatic send(logic [1:0] cmd, logic [31:0] address, logic [5:0] plen,
                      logic [7:0] zone);
    int gap;
    gap = pick_gap(smooth_req);
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid      = 1'b1;
    req_ch.cmd        = cmd;
    req_ch.address    = address;
    req_ch.prefix_len = plen;
    req_ch.zone_id    = zone;
    do @(posedge clk); while (!req_ch.ready);
    if (cmd == CMD_INSERT && known_count < SUBNETS) begin
      known_addr[known_count] = address;
      known_plen[known_count] = (plen > MAX_PREFIX) ? MAX_PREFIX : plen;
      known_count++;
    end
  endtask

  initial begin
    int r;
    int insert_pct;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.cmd        = CMD_INSERT;
    req_ch.address    = '0;
    req_ch.prefix_len = '0;
    req_ch.zone_id    = '0;
    known_count       = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Lookups on an empty table, unused command, then a small nested set of subnets and lookups into it.
    send(CMD_FIRST,   32'hC0A8_0101, 6'd0,  8'd0);
    send(CMD_LONGEST, 32'hFFFF_FFFF, 6'd63, 8'd255);
    send(CMD_UNUSED,  32'hFFFF_FFFF, 6'd63, 8'd255);
    send(CMD_INSERT,  32'hFFFF_FFFF, 6'd32, 8'd255);
    send(CMD_INSERT,  32'h0000_0000, 6'd63, 8'd0);
    send(CMD_INSERT,  32'h0A00_0000, 6'd8,  8'd1);
    send(CMD_INSERT,  32'h0A0B_0000, 6'd16, 8'd2);
    send(CMD_INSERT,  32'h0A0B_0C00, 6'd24, 8'd3);
    send(CMD_INSERT,  32'h0A0B_FFFF, 6'd16, 8'd4);
    send(CMD_FIRST,   32'h0A0B_0C0D, 6'd0,  8'd0);
    send(CMD_LONGEST, 32'h0A0B_0C0D, 6'd0,  8'd0);
    send(CMD_LONGEST, 32'h0A0B_9999, 6'd0,  8'd0);
    send(CMD_FIRST,   32'hFFFF_FFFF, 6'd0,  8'd0);
    send(CMD_LONGEST, 32'h0000_0000, 6'd0,  8'd0);
    send(CMD_LONGEST, 32'h0B00_0000, 6'd0,  8'd0);
    send(CMD_FIRST,   32'h0000_0001, 6'd0,  8'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) smooth_req = ($urandom_range(3) == 0);
      r          = $urandom_range(99);
      insert_pct = (known_count < SUBNETS) ? 25 : 8;
      if (r < insert_pct)
        send(CMD_INSERT, near_address(), pick_prefix(), 8'($urandom_range(255)));
      else if (r < insert_pct + 3)
        send(CMD_UNUSED, $urandom, 6'($urandom_range(63)), 8'($urandom_range(255)));
      else if ($urandom_range(1) == 0)
        send(CMD_FIRST, near_address(), 6'($urandom_range(63)), 8'($urandom_range(255)));
      else
        send(CMD_LONGEST, near_address(), 6'($urandom_range(63)), 8'($urandom_range(255)));
    end

    @(negedge clk);
    req_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Response back-pressure: random stalls, with some stretches of constant ready.
  initial begin
    int stall;
    int tick;
    stall        = 0;
    tick         = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (tick % 300 == 0) smooth_rsp = ($urandom_range(3) == 0);
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        stall--;
      end else begin
        rsp_ch.ready = 1'b1;
        stall = pick_gap(smooth_rsp);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: files.f
hdl/sacl_pkg.sv
hdl/sacl_req_if.sv
hdl/sacl_rsp_if.sv
hdl/sacl_cell.sv
hdl/subnet_acl_match_table.sv
bench/acl_scoreboard.sv
bench/testbench.sv
